/* src/ipv4hc_pkg.sv */
`default_nettype none

package ipv4hc_pkg;

    localparam logic [15:0] MAX_PACKET_BYTES = 16'hFFFF;
    localparam logic [31:0] BCAST_ADDR       = 32'hFFFF_FFFF;
    localparam logic [15:0] CSUM_GOOD        = 16'hFFFF;
    localparam logic [3:0]  IP_VERSION       = 4'd4;
    localparam logic [3:0]  MIN_HDR_WORDS    = 4'd5;
    localparam logic [3:0]  MAX_HDR_RESET    = 4'd12;

    // byte offsets inside the header
    localparam logic [15:0] POS_TTL        = 16'd8;
    localparam logic [15:0] POS_DEST_FIRST = 16'd16;
    localparam logic [15:0] POS_DEST_LAST  = 16'd19;

    typedef enum logic [2:0] {
        ST_ACCEPT   = 3'd0,
        ST_VERSION  = 3'd1,
        ST_HDR_LEN  = 3'd2,
        ST_TTL      = 3'd3,
        ST_DEST     = 3'd4,
        ST_CHECKSUM = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        CFG_OWN_ADDR  = 2'd0,
        CFG_MAX_WORDS = 2'd1
    } t_cfg_index;

    // header fields as seen after the current byte
    typedef struct packed {
        logic [3:0]  version;
        logic [3:0]  hdr_words;
        logic [7:0]  ttl;
        logic [31:0] dest;
        logic [15:0] csum;
        logic [15:0] length;
    } t_hdr_view;

    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

`default_nettype wire

/* src/ipv4_header_checker.sv */
// channel  | signals                                   | direction
// ---------+-------------------------------------------+----------
// in       | i_in_valid o_in_ready i_data_byte i_last_byte | to block
// out      | o_out_valid i_out_ready o_status o_packet_length | from block
// cfg      | i_cfg_valid o_cfg_ready i_cfg_index i_cfg_data | to block
//
// one byte per cycle unless a last byte waits on a stalled result; verdicts are registered.
// the rate is set by the single byte stage between the input register and the result register.
// synchronous active-low reset clears packet state and loads the configuration defaults.
// a stalled result only holds back a last byte; other bytes keep flowing.
// cfg writes are always taken; an unknown index is dropped.
`default_nettype none

module ipv4_header_checker
    import ipv4hc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_status,
    output logic [15:0]      o_packet_length,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        r_out_valid;
    t_status     r_out_status;
    logic [15:0] r_out_len;
    logic [31:0] r_own_addr;
    logic [3:0]  r_max_words;
    logic        step;
    logic        load;
    t_hdr_view   view;
    t_status     verdict;

    assign step       = r_in_valid && !(r_in_last && r_out_valid && !i_out_ready);
    assign load       = step && r_in_last;
    assign o_in_ready = !r_in_valid || step;
    assign o_cfg_ready = 1'b1;

    ipv4hc_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_view  (view)
    );

    ipv4hc_verdict u_verdict (
        .i_view      (view),
        .i_own_addr  (r_own_addr),
        .i_max_words (r_max_words),
        .o_status    (verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (load) begin
            r_out_status <= verdict;
            r_out_len    <= view.length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_addr  <= '0;
            r_max_words <= MAX_HDR_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_OWN_ADDR:  r_own_addr  <= i_cfg_data;
                CFG_MAX_WORDS: r_max_words <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_packet_length = r_out_len;

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(load))
        else $error("result raised without a last byte transfer");

    a_accept_min_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_ACCEPT) |-> (o_packet_length >= 16'd20))
        else $error("packet accepted shorter than a minimal header");

    a_short_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_packet_length < 16'd20)
            |-> (o_status == ST_VERSION || o_status == ST_HDR_LEN))
        else $error("short packet not rejected on version or length");

endmodule

`default_nettype wire

/* src/ipv4hc_accum.sv */
`default_nettype none

module ipv4hc_accum
    import ipv4hc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    output t_hdr_view       o_view
);

    logic [15:0] r_count, n_count;
    logic [3:0]  r_version, n_version;
    logic [3:0]  r_hwords, n_hwords;
    logic [7:0]  r_ttl, n_ttl;
    logic [31:0] r_dest, n_dest;
    logic [15:0] r_csum, n_csum;
    logic [7:0]  r_hold, n_hold;
    logic [5:0]  hdr_bytes;

    always_comb begin
        n_version = r_version;
        n_hwords  = r_hwords;
        n_ttl     = r_ttl;
        n_dest    = r_dest;
        n_csum    = r_csum;
        n_hold    = r_hold;
        if (r_count == 16'd0) begin
            n_version = i_byte[7:4];
            n_hwords  = i_byte[3:0];
        end
        if (r_count == POS_TTL) begin
            n_ttl = i_byte;
        end
        if (r_count >= POS_DEST_FIRST && r_count <= POS_DEST_LAST) begin
            n_dest = {r_dest[23:0], i_byte};
        end
        hdr_bytes = {n_hwords, 2'b00};
        if (r_count < {10'd0, hdr_bytes}) begin
            if (!r_count[0]) begin
                n_hold = i_byte;
            end else begin
                n_csum = ones_add(r_csum, {r_hold, i_byte});
            end
        end
        n_count = (r_count != MAX_PACKET_BYTES) ? r_count + 16'd1 : r_count;
    end

    assign o_view = '{version: n_version, hdr_words: n_hwords, ttl: n_ttl,
                      dest: n_dest, csum: n_csum, length: n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_count   <= '0;
            r_version <= '0;
            r_hwords  <= '0;
            r_ttl     <= '0;
            r_dest    <= '0;
            r_csum    <= '0;
            r_hold    <= '0;
        end else if (i_step) begin
            r_count   <= n_count;
            r_version <= n_version;
            r_hwords  <= n_hwords;
            r_ttl     <= n_ttl;
            r_dest    <= n_dest;
            r_csum    <= n_csum;
            r_hold    <= n_hold;
        end
    end

    // a new packet always starts from a clean slate
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_last) |=> (r_count == 16'd0 && r_csum == 16'd0))
        else $error("packet state not cleared after last byte");

endmodule

`default_nettype wire

/* src/ipv4hc_verdict.sv */
`default_nettype none

module ipv4hc_verdict
    import ipv4hc_pkg::*;
(
    input  wire t_hdr_view    i_view,
    input  wire logic [31:0]  i_own_addr,
    input  wire logic [3:0]   i_max_words,
    output t_status           o_status
);

    logic [5:0] hdr_bytes;
    logic       len_bad;

    always_comb begin
        hdr_bytes = {i_view.hdr_words, 2'b00};
        len_bad   = (i_view.hdr_words < MIN_HDR_WORDS) || (i_view.hdr_words > i_max_words)
                    || (i_view.length < {10'd0, hdr_bytes});
        if (i_view.version != IP_VERSION) begin
            o_status = ST_VERSION;
        end else if (len_bad) begin
            o_status = ST_HDR_LEN;
        end else if (i_view.ttl == 8'd0) begin
            o_status = ST_TTL;
        end else if (i_view.dest != i_own_addr && i_view.dest != BCAST_ADDR) begin
            o_status = ST_DEST;
        end else if (i_view.csum != CSUM_GOOD) begin
            o_status = ST_CHECKSUM;
        end else begin
            o_status = ST_ACCEPT;
        end
    end

endmodule

`default_nettype wire

/* dv/tb_ipv4_header_checker.sv */
`timescale 1ns / 100ps

module tb_ipv4_header_checker;
    import ipv4hc_pkg::*;

    // indexes past the register map, written to show they are dropped
    localparam logic [1:0] CFG_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_SPARE_B = 2'd3;

    localparam logic [3:0]  VER_IPV4    = 4'd4;
    localparam logic [3:0]  HDR_MIN     = 4'd5;
    localparam logic [31:0] ADDR_BCAST  = 32'hFFFF_FFFF;
    localparam logic [15:0] SUM_OK      = 16'hFFFF;
    localparam logic [15:0] COUNT_SAT   = 16'hFFFF;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          LONG_HOLD_CYCLES = 400;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_rx_byte;

    typedef struct packed {
        t_status     status;
        logic [15:0] length;
    } t_verdict;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [7:0]  data_byte = 8'd0;
    logic        last_byte = 1'b0;
    logic        out_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [31:0] cfg_data = 32'd0;
    logic        in_ready;
    logic        out_valid;
    logic        cfg_ready;
    logic [2:0]  status;
    logic [15:0] packet_length;

    ipv4_header_checker i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_data_byte     (data_byte),
        .i_last_byte     (last_byte),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_status        (status),
        .o_packet_length (packet_length),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // register shadow, written by the stimulus process only
    logic [31:0] own_addr_cfg;
    logic [3:0]  max_words_cfg;

    // packet state, written by the driver only
    logic [15:0] rx_count;
    logic [3:0]  rx_version;
    logic [3:0]  rx_hwords;
    logic [7:0]  rx_ttl;
    logic [31:0] rx_dest;
    logic [15:0] rx_sum;
    logic [7:0]  rx_high;

    t_rx_byte bytes_pending[$];
    t_verdict verdicts_due[$];
    int       n_queued = 0;
    int       n_taken = 0;
    int       n_fail = 0;
    logic     hold_req = 1'b0;
    logic     hold_done = 1'b0;

    task automatic clear_rx();
        rx_count   = '0;
        rx_version = '0;
        rx_hwords  = '0;
        rx_ttl     = '0;
        rx_dest    = '0;
        rx_sum     = '0;
        rx_high    = '0;
    endtask

    task automatic header_step(input logic [7:0] b, input logic last);
        logic [15:0] pos;
        logic [5:0]  hdr_bytes;
        logic [16:0] acc;
        t_verdict    v;
        pos = rx_count;
        if (pos == 16'd0) begin
            rx_version = b[7:4];
            rx_hwords  = b[3:0];
        end
        if (pos == 16'd8)
            rx_ttl = b;
        if (pos >= 16'd16 && pos <= 16'd19)
            rx_dest = {rx_dest[23:0], b};
        hdr_bytes = {rx_hwords, 2'b00};
        if (pos < hdr_bytes) begin
            if (!pos[0]) begin
                rx_high = b;
            end else begin
                // ones' complement add with end-around carry
                acc = {1'b0, rx_sum} + {1'b0, rx_high, b};
                rx_sum = acc[15:0] + acc[16];
            end
        end
        if (rx_count != COUNT_SAT)
            rx_count = rx_count + 16'd1;
        if (last) begin
            v.length = rx_count;
            if (rx_version != VER_IPV4)
                v.status = ST_VERSION;
            else if (rx_hwords < HDR_MIN || rx_hwords > max_words_cfg || rx_count < hdr_bytes)
                v.status = ST_HDR_LEN;
            else if (rx_ttl == 8'd0)
                v.status = ST_TTL;
            else if (rx_dest != own_addr_cfg && rx_dest != ADDR_BCAST)
                v.status = ST_DEST;
            else if (rx_sum != SUM_OK)
                v.status = ST_CHECKSUM;
            else
                v.status = ST_ACCEPT;
            verdicts_due.push_back(v);
            clear_rx();
        end
    endtask

    // byte driver: bursts of random length with random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin : drive_proc
        logic     offer;
        t_rx_byte x;
        if (!i_rst_n) begin
            clear_rx();
            in_valid <= 1'b0;
        end else begin
            offer = in_valid && !in_ready;
            if (in_valid && in_ready) begin
                header_step(data_byte, last_byte);
                n_taken++;
            end
            if (!offer) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (bytes_pending.size() > 0) begin
                    x = bytes_pending.pop_front();
                    data_byte <= x.data;
                    last_byte <= x.last;
                    offer = 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(64, 200)
                                                                 : $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            in_valid <= offer;
        end
    end

    // verdict receiver with its own stall pattern and one long hold-off
    int stall_mode = 0;
    int mode_left = 0;
    int hold_left = 0;

    always @(posedge i_clk) begin : receive_proc
        t_verdict v;
        logic     ready_next;
        if (i_rst_n && out_valid && out_ready) begin
            if (verdicts_due.size() == 0) begin
                $error("unexpected verdict transfer: status %0d packet_length %0d",
                       status, packet_length);
                n_fail++;
            end else begin
                v = verdicts_due.pop_front();
                if (status !== v.status) begin
                    $error("status: expected %0d, got %0d", v.status, status);
                    n_fail++;
                end
                if (packet_length !== v.length) begin
                    $error("packet_length: expected %0d, got %0d", v.length, packet_length);
                    n_fail++;
                end
            end
        end
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 200);
        end else begin
            mode_left--;
        end
        if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_left = LONG_HOLD_CYCLES;
            hold_done = 1'b1;
            ready_next = 1'b0;
        end else begin
            case (stall_mode)
                0: ready_next = 1'b1;
                1: ready_next = ($urandom_range(0, 1) == 1);
                default: ready_next = ($urandom_range(0, 4) == 0);
            endcase
        end
        out_ready <= ready_next;
    end

    task automatic push_byte(input logic [7:0] b, input logic last);
        t_rx_byte x;
        x.data = b;
        x.last = last;
        bytes_pending.push_back(x);
        n_queued++;
    endtask

    // builds a header, with a correct checksum if it holds bytes 10 and 11, then spoils or truncates on request
    task automatic send_packet(input logic [3:0] ver, input logic [3:0] hw, input logic [7:0] ttl,
                               input logic [31:0] dest, input bit good_sum, input int payload,
                               input int keep);
        logic [7:0]  hdr[60];
        logic [16:0] acc;
        logic [15:0] sum;
        int          hb;
        int          n_hdr;
        int          total;
        int          k;
        hb = hw * 4;
        n_hdr = (hb < 20) ? 20 : hb;
        for (k = 0; k < 60; k++)
            hdr[k] = 8'($urandom);
        hdr[0] = {ver, hw};
        hdr[8] = ttl;
        {hdr[16], hdr[17], hdr[18], hdr[19]} = dest;
        hdr[10] = 8'd0;
        hdr[11] = 8'd0;
        sum = 16'd0;
        for (k = 0; k < hb; k += 2) begin
            acc = {1'b0, sum} + {1'b0, hdr[k], hdr[k + 1]};
            sum = acc[15:0] + acc[16];
        end
        if (hb >= 12)
            {hdr[10], hdr[11]} = ~sum;
        if (!good_sum)
            hdr[$urandom_range(2, 7)] ^= 8'(1 << $urandom_range(0, 7));
        total = n_hdr + payload;
        if (keep > 0 && keep < total)
            total = keep;
        for (k = 0; k < total; k++)
            push_byte((k < n_hdr) ? hdr[k] : 8'($urandom), k == total - 1);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!cfg_ready)
            @(posedge i_clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_OWN_ADDR:  own_addr_cfg = val;
            CFG_MAX_WORDS: max_words_cfg = val[3:0];
            default: ;
        endcase
    endtask

    // sender pause: everything taken, every verdict in, block settled
    task automatic wait_idle();
        while (n_taken != n_queued || verdicts_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_traffic(input int n_bytes);
        int          start;
        int          n_verdicts;
        int          kind;
        int          payload;
        int          n;
        int          k;
        logic [3:0]  hw;
        logic [3:0]  hw_top;
        logic [7:0]  ttl;
        logic [31:0] dest;
        logic        last;
        start = n_queued;
        n_verdicts = 0;
        while (n_queued - start < n_bytes || n_verdicts < 2) begin
            kind = $urandom_range(0, 99);
            hw_top = (max_words_cfg >= HDR_MIN) ? max_words_cfg : 4'd15;
            hw = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, hw_top)) : HDR_MIN;
            dest = ($urandom_range(0, 2) == 0) ? ADDR_BCAST : own_addr_cfg;
            ttl = 8'($urandom_range(1, 255));
            payload = $urandom_range(0, 6);
            if (kind < 60) begin
                send_packet(VER_IPV4, hw, ttl, dest, 1'b1, payload, 0);
            end else if (kind < 67) begin
                send_packet(4'($urandom_range(5, 19) % 16), hw, ttl, dest, 1'b1, payload, 0);
            end else if (kind < 75) begin
                send_packet(VER_IPV4, 4'($urandom), ttl, dest, 1'b1, payload, 0);
            end else if (kind < 81) begin
                send_packet(VER_IPV4, hw, 8'd0, dest, 1'b1, payload, 0);
            end else if (kind < 87) begin
                send_packet(VER_IPV4, hw, ttl, $urandom, 1'b1, payload, 0);
            end else if (kind < 93) begin
                send_packet(VER_IPV4, hw, ttl, dest, 1'b0, payload, 0);
            end else if (kind < 98) begin
                send_packet(VER_IPV4, hw, ttl, dest, 1'b1, payload,
                            $urandom_range(1, hw * 4 - 1));
            end else begin
                // noise: random bytes with random packet ends
                n = $urandom_range(1, 8);
                for (k = 0; k < n; k++) begin
                    last = ($urandom_range(0, 3) == 0) || (k == n - 1);
                    push_byte(8'($urandom), last);
                    if (last)
                        n_verdicts++;
                end
                n_verdicts--;
            end
            n_verdicts++;
        end
    endtask

    initial begin : stimulus
        logic [3:0] mw;
        int         p;
        own_addr_cfg = 32'd0;
        max_words_cfg = 4'd12;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: own address zero, header limit twelve words
        send_packet(VER_IPV4, 4'd5, 8'd64, ADDR_BCAST, 1'b1, 0, 0);
        send_packet(VER_IPV4, 4'd12, 8'd1, 32'd0, 1'b1, 2, 0);
        send_packet(VER_IPV4, 4'd13, 8'd64, ADDR_BCAST, 1'b1, 0, 0);
        send_packet(4'hF, 4'd5, 8'd64, ADDR_BCAST, 1'b1, 0, 0);
        send_packet(4'h0, 4'd5, 8'd64, ADDR_BCAST, 1'b1, 0, 0);
        send_packet(VER_IPV4, 4'd4, 8'd64, ADDR_BCAST, 1'b1, 0, 0);
        send_packet(VER_IPV4, 4'd0, 8'd64, ADDR_BCAST, 1'b1, 0, 0);
        send_packet(VER_IPV4, 4'd5, 8'd0, ADDR_BCAST, 1'b1, 0, 0);
        send_packet(VER_IPV4, 4'd5, 8'd255, ADDR_BCAST, 1'b1, 3, 0);
        send_packet(VER_IPV4, 4'd5, 8'd64, 32'h0A00_0001, 1'b1, 0, 0);
        send_packet(VER_IPV4, 4'd5, 8'd64, ADDR_BCAST, 1'b0, 0, 0);
        // short packets ending inside the header
        send_packet(VER_IPV4, 4'd5, 8'd64, ADDR_BCAST, 1'b1, 0, 19);
        send_packet(4'd6, 4'd5, 8'd64, ADDR_BCAST, 1'b1, 0, 3);
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        wait_idle();

        write_reg(CFG_OWN_ADDR, ADDR_BCAST);
        write_reg(CFG_MAX_WORDS, {28'hFFF_FFFF, 4'd15});
        write_reg(CFG_SPARE_A, $urandom);
        write_reg(CFG_SPARE_B, $urandom);
        send_packet(VER_IPV4, 4'd15, 8'd9, ADDR_BCAST, 1'b1, 1, 0);
        send_packet(VER_IPV4, 4'd5, 8'd9, 32'd0, 1'b1, 0, 0);
        send_packet(VER_IPV4, 4'd15, 8'd9, ADDR_BCAST, 1'b1, 0, 40);
        wait_idle();

        // limit below the minimum: any correct version fails on header length
        write_reg(CFG_MAX_WORDS, {28'($urandom), 4'd0});
        write_reg(CFG_OWN_ADDR, 32'd0);
        send_packet(VER_IPV4, 4'd5, 8'd64, 32'd0, 1'b1, 0, 0);
        send_packet(4'd2, 4'd5, 8'd64, 32'd0, 1'b1, 0, 0);
        random_traffic(65);
        wait_idle();

        for (p = 0; p < 5; p++) begin
            if (p == 0)
                mw = HDR_MIN;
            else if (p == 3)
                mw = 4'd4;
            else
                mw = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(5, 15));
            write_reg(CFG_OWN_ADDR, $urandom);
            write_reg(CFG_MAX_WORDS, {28'($urandom), mw});
            if (p == 1)
                hold_req = 1'b1;
            random_traffic(65);
            wait_idle();
        end

        if (n_fail == 0)
            $display("ipv4_header_checker test passed");
        else
            $display("ipv4_header_checker test failed");
        $finish;
    end

    initial begin : watchdog
        #50_000_000;
        $display("ipv4_header_checker test failed");
        $finish;
    end

endmodule
